FILE: src/i2cm_pkg.sv
package i2cm_pkg;

  // Width of the read byte counter.
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned DELAY_W   = 10;
  localparam int unsigned TIMEOUT_W = 8;

  // Values that the configuration registers take after reset.
  localparam logic [DELAY_W-1:0]   DELAY_RESET   = 10'd84;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd250;

  // Configuration register indexes.
  localparam logic CFG_BIT_DELAY   = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Which byte of the command is on the bus.
  typedef enum logic [1:0] {
    STG_DEV_WR = 2'd0,
    STG_REG    = 2'd1,
    STG_DATA   = 2'd2,
    STG_DEV_RD = 2'd3
  } stage_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_SEND_LOW  = 4'd3,
    PH_SEND_HIGH = 4'd4,
    PH_ACK_LOW   = 4'd5,
    PH_ACK_HIGH  = 4'd6,
    PH_ACK_POLL  = 4'd7,
    PH_RESTART   = 4'd8,
    PH_RD_LOW    = 4'd9,
    PH_RD_HIGH   = 4'd10,
    PH_MACK_LOW  = 4'd11,
    PH_MACK_HIGH = 4'd12,
    PH_STOP_A    = 4'd13,
    PH_STOP_B    = 4'd14,
    PH_STOP_C    = 4'd15
  } phase_e;

  typedef struct packed {
    logic        sda_in;
    logic [15:0] read_count;
    logic [7:0]  write_data;
    logic [7:0]  reg_index;
    logic [6:0]  slave_addr;
    logic [1:0]  action;
  } item_t;

  typedef struct packed {
    logic       status;
    logic       done_res;
    logic       read_last;
    logic       read_valid;
    logic [7:0] read_data;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

  typedef struct packed {
    logic [DELAY_W-1:0]   bit_delay_ticks;
    logic [TIMEOUT_W-1:0] ack_timeout;
  } cfg_t;

endpackage

FILE: src/i2c_master_register_access.sv
// The result of a tick transaction is presented in the cycle after it is accepted.
// Throughput: one transaction per cycle while the consumer keeps up; each accepted
// transaction steps the sequencer, whose half-bit delay and ack timeout set bus timing.
// Reset: rst_ni is asynchronous and active low; it idles the sequencer, empties the
// output register and loads bit_delay_ticks with 84 and ack_timeout with 250.
module i2c_master_register_access
  import i2cm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [DELAY_W-1:0]   cfg_data_i,
  // Input tick stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // From bit 0: action[2], slave_addr[7], reg_index[8], write_data[8], read_count[16],
  // sda_in[1], zero fill[6].
  input  logic [47:0]          s_axis_tdata,
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // From bit 0: scl_out[1], sda_out[1], busy_res[1], read_data[8], read_valid[1],
  // done_res[1], status[1], zero fill[2].
  output logic [15:0]          m_axis_tdata,
  // Set with the final byte of a read burst.
  output logic                 m_axis_tlast
);

  cfg_t    cfg_q;
  item_t   item;
  result_t result;
  result_t res_q;
  logic    out_valid_q;
  logic    step;

  // The output register frees itself in the same cycle it is drained, so a new
  // transaction can be taken every cycle while the consumer keeps up.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign item          = s_axis_tdata[$bits(item_t)-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_delay_ticks <= DELAY_RESET;
      cfg_q.ack_timeout     <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BIT_DELAY:   cfg_q.bit_delay_ticks <= cfg_data_i;
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout     <= cfg_data_i[TIMEOUT_W-1:0];
        default:         cfg_q                 <= cfg_q;
      endcase
    end
  end

  // The sequencer steps once per accepted transaction and yields its result.
  i2cm_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.status, res_q.done_res, res_q.read_valid,
                          res_q.read_data, res_q.busy_res, res_q.sda_out, res_q.scl_out};
  assign m_axis_tlast  = res_q.read_last;

endmodule

FILE: src/i2cm_engine.sv
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  phase_e                 phase_q, phase_d;
  stage_e                 stage_q, stage_d;
  logic [DELAY_W-1:0]     delay_q, delay_d;
  logic [3:0]             bit_idx_q, bit_idx_d;
  logic [7:0]             shift_q, shift_d;
  logic [COUNT_BITS-1:0]  left_q, left_d;
  logic [TIMEOUT_W-1:0]   ack_wait_q, ack_wait_d;
  logic [6:0]             dev_q, dev_d;
  logic [7:0]             reg_q, reg_d;
  logic [7:0]             wbyte_q, wbyte_d;
  logic                   is_read_q, is_read_d;
  logic                   failed_q, failed_d;

  logic [DELAY_W-1:0]     span;
  logic [DELAY_W:0]       delay_inc;
  logic [3:0]             bit_next;
  logic [7:0]             rx_byte;
  logic                   go_cmd;

  assign span   = (cfg_i.bit_delay_ticks == '0) ? DELAY_W'(1) : cfg_i.bit_delay_ticks;
  assign go_cmd = (phase_q == PH_IDLE) &&
                  ((item_i.action == ACT_WRITE) || (item_i.action == ACT_READ));

  always_comb begin
    phase_d    = phase_q;
    stage_d    = stage_q;
    delay_d    = delay_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    left_d     = left_q;
    ack_wait_d = ack_wait_q;
    dev_d      = dev_q;
    reg_d      = reg_q;
    wbyte_d    = wbyte_q;
    is_read_d  = is_read_q;
    failed_d   = failed_q;
    result_o   = '0;
    delay_inc  = '0;
    bit_next   = '0;
    rx_byte    = '0;

    // A command taken on an idle tick already runs its first start tick.
    if (go_cmd) begin
      dev_d      = item_i.slave_addr;
      reg_d      = item_i.reg_index;
      wbyte_d    = item_i.write_data;
      is_read_d  = (item_i.action == ACT_READ);
      left_d     = COUNT_BITS'(item_i.read_count);
      if (left_d == '0) begin
        left_d = COUNT_BITS'(1);
      end
      stage_d    = STG_DEV_WR;
      failed_d   = 1'b0;
      bit_idx_d  = '0;
      ack_wait_d = '0;
      phase_d    = PH_START_A;
      delay_d    = '0;
    end

    if (phase_d == PH_IDLE) begin
      result_o.scl_out = 1'b1;
      result_o.sda_out = 1'b1;
    end else begin
      result_o.busy_res = 1'b1;
      case (phase_d)
        PH_START_B:   begin result_o.scl_out = 1'b1; result_o.sda_out = 1'b0; end
        PH_SEND_LOW:  begin result_o.scl_out = 1'b0; result_o.sda_out = shift_d[7]; end
        PH_SEND_HIGH: begin result_o.scl_out = 1'b1; result_o.sda_out = shift_d[7]; end
        PH_ACK_LOW, PH_RESTART, PH_RD_LOW: begin
          result_o.scl_out = 1'b0;
          result_o.sda_out = 1'b1;
        end
        PH_MACK_LOW:  begin result_o.scl_out = 1'b0; result_o.sda_out = (left_d == '0); end
        PH_MACK_HIGH: begin result_o.scl_out = 1'b1; result_o.sda_out = (left_d == '0); end
        PH_STOP_A:    begin result_o.scl_out = 1'b0; result_o.sda_out = 1'b0; end
        PH_STOP_B:    begin result_o.scl_out = 1'b1; result_o.sda_out = 1'b0; end
        default:      begin result_o.scl_out = 1'b1; result_o.sda_out = 1'b1; end
      endcase

      if (phase_d == PH_ACK_POLL) begin
        // One SDA sample per tick while waiting for the slave to pull low.
        if (!item_i.sda_in) begin
          case (stage_d)
            STG_DEV_WR: begin
              stage_d   = STG_REG;
              shift_d   = reg_d;
              bit_idx_d = '0;
              phase_d   = PH_SEND_LOW;
            end
            STG_REG: begin
              if (is_read_d) begin
                stage_d = STG_DEV_RD;
                phase_d = PH_RESTART;
              end else begin
                stage_d   = STG_DATA;
                shift_d   = wbyte_d;
                bit_idx_d = '0;
                phase_d   = PH_SEND_LOW;
              end
            end
            STG_DATA: phase_d = PH_STOP_A;
            default: begin
              shift_d   = '0;
              bit_idx_d = '0;
              phase_d   = PH_RD_LOW;
            end
          endcase
          delay_d = '0;
        end else if (ack_wait_d >= cfg_i.ack_timeout) begin
          failed_d = 1'b1;
          phase_d  = PH_STOP_A;
          delay_d  = '0;
        end else begin
          ack_wait_d = ack_wait_d + TIMEOUT_W'(1);
        end
      end else begin
        delay_inc = {1'b0, delay_d} + (DELAY_W+1)'(1);
        if (delay_inc < {1'b0, span}) begin
          delay_d = delay_inc[DELAY_W-1:0];
        end else begin
          delay_d  = '0;
          bit_next = bit_idx_d + 4'd1;
          case (phase_d)
            PH_START_A: phase_d = PH_START_B;
            PH_START_B: begin
              shift_d   = {dev_d, (stage_d == STG_DEV_RD)};
              bit_idx_d = '0;
              phase_d   = PH_SEND_LOW;
            end
            PH_SEND_LOW: phase_d = PH_SEND_HIGH;
            PH_SEND_HIGH: begin
              shift_d = {shift_d[6:0], 1'b0};
              if (bit_next >= 4'd8) begin
                bit_idx_d  = '0;
                ack_wait_d = '0;
                phase_d    = PH_ACK_LOW;
              end else begin
                bit_idx_d = bit_next;
                phase_d   = PH_SEND_LOW;
              end
            end
            PH_ACK_LOW:  phase_d = PH_ACK_HIGH;
            PH_ACK_HIGH: phase_d = PH_ACK_POLL;
            PH_RESTART:  phase_d = PH_START_A;
            PH_RD_LOW:   phase_d = PH_RD_HIGH;
            PH_RD_HIGH: begin
              rx_byte = {shift_d[6:0], item_i.sda_in};
              shift_d = rx_byte;
              if (bit_next >= 4'd8) begin
                bit_idx_d           = '0;
                result_o.read_data  = rx_byte;
                result_o.read_valid = 1'b1;
                result_o.read_last  = (left_d <= COUNT_BITS'(1));
                if (left_d != '0) begin
                  left_d = left_d - COUNT_BITS'(1);
                end
                phase_d = PH_MACK_LOW;
              end else begin
                bit_idx_d = bit_next;
                phase_d   = PH_RD_LOW;
              end
            end
            PH_MACK_LOW: phase_d = PH_MACK_HIGH;
            PH_MACK_HIGH: begin
              if (left_d != '0) begin
                shift_d   = '0;
                bit_idx_d = '0;
                phase_d   = PH_RD_LOW;
              end else begin
                phase_d = PH_STOP_A;
              end
            end
            PH_STOP_A: phase_d = PH_STOP_B;
            PH_STOP_B: phase_d = PH_STOP_C;
            PH_STOP_C: begin
              result_o.done_res = 1'b1;
              result_o.status   = failed_d;
              phase_d           = PH_IDLE;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      stage_q    <= STG_DEV_WR;
      delay_q    <= '0;
      bit_idx_q  <= '0;
      shift_q    <= '0;
      left_q     <= '0;
      ack_wait_q <= '0;
      dev_q      <= '0;
      reg_q      <= '0;
      wbyte_q    <= '0;
      is_read_q  <= 1'b0;
      failed_q   <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      stage_q    <= stage_d;
      delay_q    <= delay_d;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
      left_q     <= left_d;
      ack_wait_q <= ack_wait_d;
      dev_q      <= dev_d;
      reg_q      <= reg_d;
      wbyte_q    <= wbyte_d;
      is_read_q  <= is_read_d;
      failed_q   <= failed_d;
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import i2cm_pkg::*;

  // The watchdog ends the run here. The slowest legal run, with every tick
  // transaction hit by the longest source gap and sink stall, stays several
  // times below it.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 100;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_index_i;
  logic [DELAY_W-1:0]   cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // From bit 0: action, slave_addr, reg_index, write_data, read_count, sda_in, zero fill.
  logic [47:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // From bit 0: scl_out, sda_out, busy_res, read_data, read_valid, done_res, status,
  // zero fill.
  logic [15:0]          m_axis_tdata;
  logic                 m_axis_tlast;

  i2c_master_register_access dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the bus sequencer. It advances once per accepted tick
  // transaction and yields the drive levels and read results that the block
  // must present for that tick.
  // ---------------------------------------------------------------------------
  phase_e                bus_phase;
  logic [DELAY_W-1:0]    seg_count;
  logic [3:0]            bit_pos;
  logic [7:0]            shift_q;
  logic [COUNT_BITS-1:0] bytes_due;
  logic [TIMEOUT_W-1:0]  ack_polls;
  logic [6:0]            dev_hold;
  logic [7:0]            reg_hold;
  logic [7:0]            wr_hold;
  logic                  rd_hold;
  stage_e                byte_stage;
  logic                  nack_seen;
  logic [DELAY_W-1:0]    delay_cfg;
  logic [TIMEOUT_W-1:0]  timeout_cfg;

  // Expected results, oldest first, and bookkeeping for the summary.
  result_t     tick_results_q[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned items_sent;
  int unsigned writes_run;
  int unsigned reads_run;
  int unsigned bytes_seen;
  int unsigned aborts_seen;

  // Stimulus knobs. The emulated slave pulls SDA low to acknowledge; it can
  // hold SDA high for a while first, or refuse outright at one byte stage.
  bit          idle_on;
  int unsigned late_ack_pct;
  bit          refuse_on;
  stage_e      refuse_stage;

  function automatic void go_phase(phase_e p);
    bus_phase = p;
    seg_count = '0;
  endfunction

  function automatic void load_shift(logic [7:0] b);
    shift_q = b;
    bit_pos = '0;
    go_phase(PH_SEND_LOW);
  endfunction

  function automatic result_t predict_tick(item_t it);
    result_t  r;
    logic [DELAY_W:0] span;
    r = '0;
    span = (delay_cfg == '0) ? (DELAY_W+1)'(1) : {1'b0, delay_cfg};

    // A command is only taken while idle; this tick is already the first of
    // the start condition.
    if (bus_phase == PH_IDLE && (it.action == ACT_WRITE || it.action == ACT_READ)) begin
      dev_hold   = it.slave_addr;
      reg_hold   = it.reg_index;
      wr_hold    = it.write_data;
      rd_hold    = (it.action == ACT_READ);
      bytes_due  = it.read_count[COUNT_BITS-1:0];
      if (bytes_due == '0) begin
        bytes_due = COUNT_BITS'(1);
      end
      byte_stage = STG_DEV_WR;
      nack_seen  = 1'b0;
      bit_pos    = '0;
      ack_polls  = '0;
      go_phase(PH_START_A);
    end

    if (bus_phase == PH_IDLE) begin
      r.scl_out = 1'b1;
      r.sda_out = 1'b1;
      return r;
    end

    // Drive levels follow the phase held at the start of the tick.
    r.scl_out  = 1'b1;
    r.sda_out  = 1'b1;
    r.busy_res = 1'b1;
    case (bus_phase)
      PH_START_B: r.sda_out = 1'b0;
      PH_SEND_LOW: begin
        r.scl_out = 1'b0;
        r.sda_out = shift_q[7];
      end
      PH_SEND_HIGH: r.sda_out = shift_q[7];
      PH_ACK_LOW, PH_RESTART, PH_RD_LOW: r.scl_out = 1'b0;
      PH_MACK_LOW: begin
        r.scl_out = 1'b0;
        r.sda_out = (bytes_due == '0);
      end
      PH_MACK_HIGH: r.sda_out = (bytes_due == '0);
      PH_STOP_A: begin
        r.scl_out = 1'b0;
        r.sda_out = 1'b0;
      end
      PH_STOP_B: r.sda_out = 1'b0;
      default: ;
    endcase

    // Acknowledge polling takes one SDA sample per tick, independent of the
    // segment delay.
    if (bus_phase == PH_ACK_POLL) begin
      if (!it.sda_in) begin
        case (byte_stage)
          STG_DEV_WR: begin
            byte_stage = STG_REG;
            load_shift(reg_hold);
          end
          STG_REG: begin
            if (rd_hold) begin
              byte_stage = STG_DEV_RD;
              go_phase(PH_RESTART);
            end else begin
              byte_stage = STG_DATA;
              load_shift(wr_hold);
            end
          end
          STG_DATA: go_phase(PH_STOP_A);
          default: begin
            shift_q = '0;
            bit_pos = '0;
            go_phase(PH_RD_LOW);
          end
        endcase
      end else if (ack_polls >= timeout_cfg) begin
        nack_seen = 1'b1;
        go_phase(PH_STOP_A);
      end else begin
        ack_polls = ack_polls + 1'b1;
      end
      return r;
    end

    if ({1'b0, seg_count} + 1 < span) begin
      seg_count = seg_count + 1'b1;
      return r;
    end
    seg_count = '0;

    case (bus_phase)
      PH_START_A: go_phase(PH_START_B);
      PH_START_B: load_shift({dev_hold, byte_stage == STG_DEV_RD});
      PH_SEND_LOW: go_phase(PH_SEND_HIGH);
      PH_SEND_HIGH: begin
        shift_q = {shift_q[6:0], 1'b0};
        bit_pos = bit_pos + 1'b1;
        if (bit_pos >= 8) begin
          bit_pos   = '0;
          ack_polls = '0;
          go_phase(PH_ACK_LOW);
        end else begin
          go_phase(PH_SEND_LOW);
        end
      end
      PH_ACK_LOW: go_phase(PH_ACK_HIGH);
      PH_ACK_HIGH: go_phase(PH_ACK_POLL);
      PH_RESTART: go_phase(PH_START_A);
      PH_RD_LOW: go_phase(PH_RD_HIGH);
      PH_RD_HIGH: begin
        shift_q = {shift_q[6:0], it.sda_in};
        bit_pos = bit_pos + 1'b1;
        if (bit_pos >= 8) begin
          bit_pos      = '0;
          r.read_data  = shift_q;
          r.read_valid = 1'b1;
          r.read_last  = (bytes_due <= 1);
          if (bytes_due != '0) begin
            bytes_due = bytes_due - 1'b1;
          end
          go_phase(PH_MACK_LOW);
        end else begin
          go_phase(PH_RD_LOW);
        end
      end
      PH_MACK_LOW: go_phase(PH_MACK_HIGH);
      PH_MACK_HIGH: begin
        if (bytes_due != '0) begin
          shift_q = '0;
          bit_pos = '0;
          go_phase(PH_RD_LOW);
        end else begin
          go_phase(PH_STOP_A);
        end
      end
      PH_STOP_A: go_phase(PH_STOP_B);
      PH_STOP_B: go_phase(PH_STOP_C);
      PH_STOP_C: begin
        r.done_res = 1'b1;
        r.status   = nack_seen;
        go_phase(PH_IDLE);
      end
      default: go_phase(PH_IDLE);
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog and sink back-pressure.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Watchdog expired after %0d cycles.", cycle_cnt);
    $display("Mismatches found");
    $finish;
  end

  // The sink drops tready in random bursts while idling is on.
  initial begin
    int unsigned stall_len;
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_len = $urandom_range(1, 19);
        m_axis_tready <= 1'b0;
        repeat (stall_len - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: every result transaction is compared with the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("field %s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tick_results_q.size() == 0) begin
        $error("result transaction arrived with no expected result pending");
        mismatch_cnt++;
      end else begin
        want = tick_results_q.pop_front();
        check_field("scl_out",    want.scl_out,    m_axis_tdata[0]);
        check_field("sda_out",    want.sda_out,    m_axis_tdata[1]);
        check_field("busy_res",   want.busy_res,   m_axis_tdata[2]);
        check_field("read_data",  want.read_data,  m_axis_tdata[10:3]);
        check_field("read_valid", want.read_valid, m_axis_tdata[11]);
        check_field("read_last",  want.read_last,  m_axis_tlast);
        check_field("done_res",   want.done_res,   m_axis_tdata[12]);
        check_field("status",     want.status,     m_axis_tdata[13]);
        if (want.read_valid) begin
          bytes_seen++;
        end
        if (want.done_res && want.status) begin
          aborts_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Sends one tick transaction, after an optional source gap, and records what
  // the block must answer once it is accepted.
  task automatic send_tick(item_t it);
    int unsigned gap_len;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap_len = $urandom_range(1, 19);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap_len - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, it};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tick_results_q.push_back(predict_tick(it));
    items_sent++;
  endtask

  // Stops the source and waits until every expected result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_register(logic idx, logic [DELAY_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_BIT_DELAY) begin
      delay_cfg = value;
    end else begin
      timeout_cfg = value[TIMEOUT_W-1:0];
    end
  endtask

  task automatic set_timing(logic [DELAY_W-1:0] delay, logic [TIMEOUT_W-1:0] timeout);
    set_register(CFG_BIT_DELAY, delay);
    set_register(CFG_ACK_TIMEOUT, {{(DELAY_W-TIMEOUT_W){1'b0}}, timeout});
  endtask

  // Random tick content. SDA follows the emulated slave while an acknowledge
  // is polled and is random otherwise, which also makes up the read data.
  function automatic item_t next_item(action_e act);
    item_t it;
    it.action     = act;
    it.slave_addr = 7'($urandom_range(0, 127));
    it.reg_index  = 8'($urandom_range(0, 255));
    it.write_data = 8'($urandom_range(0, 255));
    it.read_count = 16'($urandom_range(0, 65535));
    if (bus_phase == PH_ACK_POLL) begin
      if (refuse_on && byte_stage == refuse_stage) begin
        it.sda_in = 1'b1;
      end else begin
        it.sda_in = ($urandom_range(0, 99) < late_ack_pct);
      end
    end else begin
      it.sda_in = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // Mostly plain ticks; commands sent while busy must be ignored, and code 3
  // behaves as a plain tick.
  function automatic action_e filler_action();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      return ACT_TICK;
    end else if (pick == 7) begin
      return ACT_WRITE;
    end else if (pick == 8) begin
      return ACT_READ;
    end
    return ACT_NONE;
  endfunction

  task automatic tick_until_idle();
    while (bus_phase != PH_IDLE) send_tick(next_item(filler_action()));
  endtask

  // Sends the command transaction only; the caller runs the ticks after it.
  task automatic start_command(action_e act, logic [6:0] dev, logic [7:0] regad,
                               logic [7:0] wdata, logic [15:0] count);
    item_t it;
    it            = next_item(act);
    it.slave_addr = dev;
    it.reg_index  = regad;
    it.write_data = wdata;
    it.read_count = count;
    send_tick(it);
    if (act == ACT_READ) begin
      reads_run++;
    end else begin
      writes_run++;
    end
  endtask

  task automatic run_command(action_e act, logic [6:0] dev, logic [7:0] regad,
                             logic [7:0] wdata, logic [15:0] count);
    tick_until_idle();
    start_command(act, dev, regad, wdata, count);
    tick_until_idle();
  endtask

  task automatic run_random_command(int unsigned max_count);
    action_e act;
    act = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
    run_command(act, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 16'($urandom_range(0, max_count)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Idle bus after reset: both lines released, nothing busy, code 3 ignored.
  task automatic test_idle_ticks();
    repeat (3) send_tick(next_item(ACT_TICK));
    repeat (3) send_tick(next_item(ACT_NONE));
  endtask

  // A register write with the reset timing, which must hold the first start
  // half for 84 ticks. The delay is then cut to zero and the address refused
  // at the first poll, so the command ends quickly.
  task automatic test_default_write();
    start_command(ACT_WRITE, 7'h50, 8'h0F, 8'hA5, 16'd1);
    repeat (90) send_tick(next_item(filler_action()));
    set_timing('0, '0);
    refuse_on    = 1'b1;
    refuse_stage = STG_DEV_WR;
    tick_until_idle();
    refuse_on    = 1'b0;
  endtask

  // Zero segment delay and zero acknowledge timeout with the largest addresses.
  // A read count of zero must behave as a single byte.
  task automatic test_zero_settings();
    set_timing('0, '0);
    run_command(ACT_READ, 7'h7F, 8'hFF, 8'hFF, 16'd0);
  endtask

  // The slave refuses the data byte of a write and the read address of a read.
  // The refused read carries the largest burst length, which never gets to run.
  task automatic test_ack_refused();
    set_timing(10'd0, 8'd1);
    refuse_on    = 1'b1;
    refuse_stage = STG_DATA;
    run_command(ACT_WRITE, 7'h13, 8'h01, 8'hC3, 16'd1);
    refuse_stage = STG_DEV_RD;
    run_command(ACT_READ, 7'h14, 8'h7E, 8'h00, 16'hFFFF);
    refuse_on    = 1'b0;
  endtask

  // Largest segment delay holds the start condition; the delay is then cut to
  // zero and the address refused at once to keep it short.
  task automatic test_max_delay();
    set_timing(10'd1023, 8'd0);
    refuse_on    = 1'b1;
    refuse_stage = STG_DEV_WR;
    start_command(ACT_WRITE, 7'h55, 8'h66, 8'h77, 16'd1);
    repeat (40) send_tick(next_item(filler_action()));
    set_register(CFG_BIT_DELAY, 10'd0);
    tick_until_idle();
    refuse_on    = 1'b0;
  endtask

  // Register writes must take effect at once, even with a command under way.
  task automatic test_config_during_command();
    set_timing(10'd3, 8'd2);
    start_command(ACT_WRITE, 7'h21, 8'h42, 8'h84, 16'd1);
    repeat (15) send_tick(next_item(filler_action()));
    set_timing(10'd1, 8'd3);
    repeat (10) send_tick(next_item(filler_action()));
    set_register(CFG_BIT_DELAY, 10'd0);
    tick_until_idle();
  endtask

  // Mostly well-formed commands with random content and short timing, some late
  // or refused acknowledges, and stretches with and without idling.
  task automatic test_random_traffic();
    int unsigned first_item;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        set_timing(($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 1))
                                              : 10'($urandom_range(2, 3)),
                   8'($urandom_range(0, 6)));
      end
      idle_on      = ($urandom_range(0, 3) != 0);
      late_ack_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : 0;
      refuse_on    = ($urandom_range(0, 9) == 0);
      refuse_stage = stage_e'($urandom_range(0, 3));
      run_random_command(($urandom_range(0, 4) == 0) ? 3 : 1);
    end
    refuse_on    = 1'b0;
    late_ack_pct = 0;
  endtask

  // Last stretch at full rate: no source gaps and no sink stalls.
  task automatic test_full_rate();
    idle_on = 1'b0;
    set_timing(10'd0, 8'd1);
    run_random_command(2);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_BIT_DELAY;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;

    bus_phase    = PH_IDLE;
    seg_count    = '0;
    bit_pos      = '0;
    shift_q      = '0;
    bytes_due    = '0;
    ack_polls    = '0;
    dev_hold     = '0;
    reg_hold     = '0;
    wr_hold      = '0;
    rd_hold      = 1'b0;
    byte_stage   = STG_DEV_WR;
    nack_seen    = 1'b0;
    delay_cfg    = DELAY_RESET;
    timeout_cfg  = TIMEOUT_RESET;

    mismatch_cnt = 0;
    cycle_cnt    = 0;
    items_sent   = 0;
    writes_run   = 0;
    reads_run    = 0;
    bytes_seen   = 0;
    aborts_seen  = 0;
    idle_on      = 1'b1;
    late_ack_pct = 0;
    refuse_on    = 1'b0;
    refuse_stage = STG_DEV_WR;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_ticks();
    test_default_write();
    test_zero_settings();
    test_ack_refused();
    test_max_delay();
    test_config_during_command();
    test_random_traffic();
    test_full_rate();

    // Every result is back; keep clocking the output register in case the block
    // emits anything it should not.
    drain_results();
    repeat (4) @(posedge clk_i);

    $display("Covered %0d tick transactions in %0d cycles: %0d register writes, %0d reads.",
             items_sent, cycle_cnt, writes_run, reads_run);
    $display("Received %0d read bytes; %0d commands ended without acknowledge.",
             bytes_seen, aborts_seen);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
